/* rtl/smh_pkg.sv */
// ----------------------------------------------------------------------------
// smh_pkg
// Shared types, constants and round functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package smh_pkg;

  // One input item: a big-endian message word with its valid byte count.
  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        final_word;
  } in_item_t;

  // One result item: a digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;
  } out_item_t;

  // Sixteen message words, word 0 first, and eight hash words, a first.
  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0]  hash_t;

  // Control from the sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic load_iv;
  } comp_ctrl_t;

  // Status from the compression unit back to the sequencer.
  typedef struct packed {
    logic busy;
  } comp_stat_t;

  // Initial hash value, word 0 in the low slot.
  localparam hash_t IV_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Round constants.
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* rtl/smh_stream_if.sv */
// ----------------------------------------------------------------------------
// smh_stream_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface smh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/smh_compress.sv */
// ----------------------------------------------------------------------------
// smh_compress
// Iterative SHA-256 compression: one round per cycle for 64 rounds, then
// a final step folds the working variables into the chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module smh_compress (
  input  logic               clk,
  input  logic               rst,
  input  smh_pkg::comp_ctrl_t ctl,
  input  smh_pkg::block_t    blk,
  output smh_pkg::comp_stat_t stat,
  output smh_pkg::hash_t     chain
);
  import smh_pkg::*;

  hash_t       vars;
  block_t      sched;
  logic        busy;
  logic        adding;
  logic [5:0]  rnd;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sched_new;

  // Round function and message schedule expansion.
  always_comb begin
    t1 = vars[7] + big_sigma1(vars[4]) + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + K_TAB[rnd] + sched[0];
    t2 = big_sigma0(vars[0])
       + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    sched_new = sched[0] + small_sigma0(sched[1]) + sched[9] + small_sigma1(sched[14]);
  end

  assign stat.busy = busy;

  // Round counter and chaining value.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      adding <= 1'b0;
      rnd    <= '0;
      chain  <= IV_HASH;
    end else begin
      if (ctl.load_iv) begin
        chain <= IV_HASH;
      end
      if (ctl.start) begin
        busy   <= 1'b1;
        adding <= 1'b0;
        rnd    <= '0;
      end else if (busy && !adding) begin
        if (rnd == 6'd63) begin
          adding <= 1'b1;
        end
        rnd <= rnd + 6'd1;
      end else if (busy) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
        busy   <= 1'b0;
        adding <= 1'b0;
      end
    end
  end

  // Working variables and the sixteen-word schedule window.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      vars  <= chain;
      sched <= blk;
    end else if (busy && !adding) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
      sched   <= {sched_new, sched[15:1]};
    end
  end

endmodule

`default_nettype wire

/* rtl/sha256_message_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// SHA-256 hasher over a byte-granular stream of big-endian words, with
// padding, length append and an eight-word digest output.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                  Transfer
//   msg      in   msg_word, byte_count, final_word         valid & ready
//   digest   out  digest_word, word_index, last_of_digest  valid & ready
//
// Message words are accepted back to back while the block line has room.
// Each completed 64-byte block then holds the input while the round unit
// runs 64 rounds and folds the result into the chaining value. After a
// final word the padding words follow, then one or two more blocks, then
// eight digest transfers.
// Reset is synchronous and returns the chaining value to the initial hash.
// A stalled digest transfer holds the block; no input is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher_unit (
  input  logic         clk,
  input  logic         rst,
  smh_stream_if.sink   msg,
  smh_stream_if.source digest
);
  import smh_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_COMP = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic [2:0] PH_NONE  = 3'd0;
  localparam logic [2:0] PH_PAD80 = 3'd1;
  localparam logic [2:0] PH_ZERO  = 3'd2;
  localparam logic [2:0] PH_LENLO = 3'd3;
  localparam logic [2:0] PH_FIN   = 3'd4;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  logic [1:0]  state;
  logic [2:0]  phase;
  logic [4:0]  wcnt;
  logic [1:0]  accn;
  logic [31:0] acc;
  block_t      buffer;
  logic [63:0] bit_length;
  logic        out_valid;
  logic [2:0]  out_idx;

  comp_ctrl_t  ctl;
  comp_stat_t  stat;
  hash_t       chain;

  logic        run_ok;
  logic        take;
  logic        len_point;
  logic [2:0]  in_cnt;
  logic [31:0] m_word;
  logic [2:0]  m_cnt;
  logic        m_do;
  logic [31:0] m_mask;
  logic [63:0] cat;
  logic [2:0]  total;
  logic        push;
  logic        out_xfer;

  // Handshake and sequencing conditions.
  assign run_ok    = (state == ST_RUN) && (wcnt != 5'd16);
  assign msg.ready = run_ok && (phase == PH_NONE);
  assign take      = msg.valid && msg.ready;
  assign in_cnt    = (msg.payload.byte_count > 3'd4) ? 3'd4 : msg.payload.byte_count;
  assign len_point = (wcnt == 5'd14) && (accn == 2'd0);

  // Select what enters the byte packer this cycle.
  always_comb begin
    m_word = '0;
    m_cnt  = '0;
    m_do   = 1'b0;
    unique case (phase)
      PH_NONE: begin
        m_word = msg.payload.msg_word;
        m_cnt  = in_cnt;
        m_do   = take;
      end
      PH_PAD80: begin
        m_word = PAD_WORD;
        m_cnt  = 3'd1;
        m_do   = run_ok;
      end
      PH_ZERO: begin
        if (len_point) begin
          m_word = bit_length[63:32];
          m_cnt  = 3'd4;
        end else begin
          m_word = '0;
          m_cnt  = 3'd4 - {1'b0, accn};
        end
        m_do = run_ok;
      end
      PH_LENLO: begin
        m_word = bit_length[31:0];
        m_cnt  = 3'd4;
        m_do   = run_ok;
      end
      default: begin
        m_do = 1'b0;
      end
    endcase
  end

  // Byte packer: append the valid bytes behind the pending partial word.
  always_comb begin
    unique case (m_cnt)
      3'd0:    m_mask = 32'h0000_0000;
      3'd1:    m_mask = 32'hff00_0000;
      3'd2:    m_mask = 32'hffff_0000;
      3'd3:    m_mask = 32'hffff_ff00;
      default: m_mask = 32'hffff_ffff;
    endcase
    cat   = {acc, 32'h0} | ({m_word & m_mask, 32'h0} >> {accn, 3'b000});
    total = {1'b0, accn} + m_cnt;
    push  = total[2];
  end

  // Compression unit control.
  assign out_xfer    = out_valid && digest.ready;
  assign ctl.start   = (state == ST_RUN) && (wcnt == 5'd16);
  assign ctl.load_iv = out_xfer && (out_idx == 3'd7);

  smh_compress u_compress (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .blk   (buffer),
    .stat  (stat),
    .chain (chain)
  );

  // Digest output from the chaining value.
  assign digest.valid                  = out_valid;
  assign digest.payload.digest_word    = chain[out_idx];
  assign digest.payload.word_index     = out_idx;
  assign digest.payload.last_of_digest = (out_idx == 3'd7);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      phase      <= PH_NONE;
      wcnt       <= '0;
      accn       <= '0;
      bit_length <= '0;
      out_valid  <= 1'b0;
      out_idx    <= '0;
    end else begin
      if (take) begin
        bit_length <= bit_length + {58'b0, in_cnt, 3'b000};
      end
      unique case (state)
        ST_RUN: begin
          if (wcnt == 5'd16) begin
            state <= ST_COMP;
            wcnt  <= '0;
          end else if (phase == PH_FIN) begin
            state     <= ST_OUT;
            out_valid <= 1'b1;
            out_idx   <= '0;
          end else if (m_do) begin
            wcnt <= wcnt + {4'b0, push};
            accn <= total[1:0];
            priority case (phase)
              PH_NONE:  if (msg.payload.final_word) phase <= PH_PAD80;
              PH_PAD80: phase <= PH_ZERO;
              PH_ZERO:  if (len_point) phase <= PH_LENLO;
              PH_LENLO: phase <= PH_FIN;
              default:  phase <= phase;
            endcase
          end
        end
        ST_COMP: begin
          if (!stat.busy) begin
            state <= ST_RUN;
          end
        end
        ST_OUT: begin
          if (out_xfer) begin
            if (out_idx == 3'd7) begin
              out_valid  <= 1'b0;
              state      <= ST_RUN;
              phase      <= PH_NONE;
              bit_length <= '0;
              accn       <= '0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // Partial word and the sixteen-word block line.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (m_do) begin
      acc <= push ? cat[31:0] : cat[63:32];
      if (push) begin
        buffer <= {cat[63:32], buffer[15:1]};
      end
    end
  end

  // Input and output are never open in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input accepted while digest pending");

  // A started block keeps the round unit busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> stat.busy)
    else $error("round unit not busy after start");

  // The digest only appears once padding is complete and the line is empty.
  a_digest_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(digest.valid) |-> (phase == PH_FIN && wcnt == 5'd0 && accn == 2'd0))
    else $error("digest shown before padding finished");

endmodule

`default_nettype wire
